@@ src/ldlt_pkg.sv @@
// ----------------------------------------------------------------------------
// ldlt_pkg
// Shared constants, types and helpers of the unpivoted LDL^T factor unit.
// ----------------------------------------------------------------------------
package ldlt_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 52;
    localparam int QUO_W     = 48;
    localparam int SIZE_W    = 4;
    localparam int OP_W      = 3;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_LDT   = 3'd1;  // load diagonal operand
    localparam logic [OP_W-1:0] OP_VMUL  = 3'd2;  // v[i] = A(k,i) * A(i,i)
    localparam logic [OP_W-1:0] OP_LDACC = 3'd3;  // acc = entry
    localparam logic [OP_W-1:0] OP_MAC   = 3'd4;  // acc -= entry * v[i]
    localparam logic [OP_W-1:0] OP_OUT   = 3'd5;  // read entry into output reg
    localparam logic [OP_W-1:0] OP_FDIAG = 3'd6;  // write pivot D(k)
    localparam logic [OP_W-1:0] OP_FOFF  = 3'd7;  // write quotient L(r,k)

    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  vidx;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              clr;
        logic              ld_we;
        logic [ADDR_W-1:0] ld_addr;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_full;
    } t_stat;

    typedef struct packed {
        logic  sat;
        t_data val;
    } t_sat;

    function automatic t_sat sat64(input logic signed [63:0] x);
        t_sat s;
        s.sat = 1'b0;
        s.val = x[DATA_W-1:0];
        if (x > SAT_HI) begin
            s.sat = 1'b1;
            s.val = SAT_HI[DATA_W-1:0];
        end else if (x < SAT_LO) begin
            s.sat = 1'b1;
            s.val = SAT_LO[DATA_W-1:0];
        end
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        return {col, row};
    endfunction

    // ceil(1024 / n), exact enough for counts below 64
    function automatic logic [10:0] recip(input logic [SIZE_W-1:0] n);
        logic [10:0] r;
        case (n)
            4'd2:    r = 11'd512;
            4'd3:    r = 11'd342;
            4'd4:    r = 11'd256;
            4'd5:    r = 11'd205;
            4'd6:    r = 11'd171;
            4'd7:    r = 11'd147;
            4'd8:    r = 11'd128;
            default: r = 11'd1024;
        endcase
        return r;
    endfunction

endpackage

@@ src/ldlt_if.sv @@
// ----------------------------------------------------------------------------
// ldlt_if
// Valid/ready channels of the factor unit: entries in, results out, size.
// ----------------------------------------------------------------------------
interface ldlt_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   entry_value;
    logic                 last_entry;
    modport source (output valid, entry_value, last_entry, input ready);
    modport sink   (input valid, entry_value, last_entry, output ready);
endinterface

interface ldlt_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   result_value;
    logic [2:0]           row_index;
    logic [2:0]           col_index;
    logic                 singular;
    logic                 saturated;
    logic                 last_result;
    modport source (output valid, result_value, row_index, col_index, singular,
                    saturated, last_result, input ready);
    modport sink   (input valid, result_value, row_index, col_index, singular,
                    saturated, last_result, output ready);
endinterface

interface ldlt_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] matrix_size;
    modport source (output valid, matrix_size, input ready);
    modport sink   (input valid, matrix_size, output ready);
endinterface

@@ src/ldlt_factor_unpivoted_unit.sv @@
// ----------------------------------------------------------------------------
// ldlt_factor_unpivoted_unit
// In-place LDL^T factorization of a symmetric Q16.16 matrix, order 1..8.
// ----------------------------------------------------------------------------
// Entries load while the unit is idle; the last entry starts the factorization.
// Each multiply-accumulate issues into a two-stage pipeline, with a short drain
// per dot product; each off-diagonal quotient comes from the bit-serial divider.
// Results leave one entry at a time; the next is read once the sink takes the previous.
// Synchronous active-low reset clears control and flags; the store is not cleared.
module ldlt_factor_unpivoted_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ldlt_in_if.sink        i_in_ch,
    ldlt_out_if.source     o_out_ch,
    ldlt_cfg_if.sink       i_cfg_ch
);

    ldlt_pkg::t_cmd  cmd;
    ldlt_pkg::t_stat stat;

    ldlt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_ch.valid),
        .o_in_ready   (i_in_ch.ready),
        .i_last_entry (i_in_ch.last_entry),
        .i_cfg_valid  (i_cfg_ch.valid),
        .o_cfg_ready  (i_cfg_ch.ready),
        .i_cfg_size   (i_cfg_ch.matrix_size),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    ldlt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_entry        (i_in_ch.entry_value),
        .o_out_valid    (o_out_ch.valid),
        .i_out_ready    (o_out_ch.ready),
        .o_result_value (o_out_ch.result_value),
        .o_row_index    (o_out_ch.row_index),
        .o_col_index    (o_out_ch.col_index),
        .o_singular     (o_out_ch.singular),
        .o_saturated    (o_out_ch.saturated),
        .o_last_result  (o_out_ch.last_result)
    );

endmodule

@@ src/ldlt_div.sv @@
// ----------------------------------------------------------------------------
// ldlt_div
// Radix-2 restoring divider: (num * 2^16) / den, truncated toward zero.
// ----------------------------------------------------------------------------
module ldlt_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ldlt_pkg::t_data      i_num,
    input  ldlt_pkg::t_data      i_den,
    output logic                 o_run,
    output logic                 o_done,
    output logic signed [63:0]   o_quo
);

    logic                          r_run, n_run;
    logic                          r_done, n_done;
    logic [5:0]                    r_cnt, n_cnt;
    logic [ldlt_pkg::DATA_W-1:0]   r_rem, n_rem;
    logic [ldlt_pkg::QUO_W-1:0]    r_num, n_num;
    logic [ldlt_pkg::QUO_W-1:0]    r_quo, n_quo;
    logic [ldlt_pkg::DATA_W-1:0]   r_den, n_den;
    logic                          r_neg, n_neg;
    logic [ldlt_pkg::DATA_W:0]     rem_sh;
    logic [ldlt_pkg::DATA_W-1:0]   mag_num, mag_den;
    logic [63:0]                   quo_ext;

    always_comb begin
        mag_num = i_num[31] ? (~i_num + 32'd1) : i_num;
        mag_den = i_den[31] ? (~i_den + 32'd1) : i_den;
        rem_sh  = {r_rem, r_num[ldlt_pkg::QUO_W-1]};
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_num   = r_num;
        n_quo   = r_quo;
        n_den   = r_den;
        n_neg   = r_neg;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = 6'(ldlt_pkg::QUO_W - 1);
            n_rem = '0;
            n_num = {mag_num, 16'd0};
            n_quo = '0;
            n_den = mag_den;
            n_neg = i_num[31] ^ i_den[31];
        end else if (r_run) begin
            n_num = {r_num[ldlt_pkg::QUO_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = 32'(rem_sh - {1'b0, r_den});
                n_quo = {r_quo[ldlt_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[31:0];
                n_quo = {r_quo[ldlt_pkg::QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign quo_ext = {16'd0, r_quo};
    assign o_quo   = r_neg ? -$signed(quo_ext) : $signed(quo_ext);
    assign o_run   = r_run;
    assign o_done  = r_done;

endmodule

@@ src/ldlt_dp.sv @@
// ----------------------------------------------------------------------------
// ldlt_dp
// Datapath: matrix store, multiply-accumulate pipeline, divider, output reg.
// ----------------------------------------------------------------------------
module ldlt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ldlt_pkg::t_cmd       i_cmd,
    output ldlt_pkg::t_stat      o_stat,
    input  ldlt_pkg::t_data      i_entry,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ldlt_pkg::t_data      o_result_value,
    output logic [2:0]           o_row_index,
    output logic [2:0]           o_col_index,
    output logic                 o_singular,
    output logic                 o_saturated,
    output logic                 o_last_result
);

    ldlt_pkg::t_data                 r_mem [64];
    ldlt_pkg::t_data                 r_rdata;
    ldlt_pkg::t_data                 r_v [ldlt_pkg::MAX_ORDER];
    ldlt_pkg::t_data                 r_t;
    ldlt_pkg::t_data                 r_d;
    logic signed [63:0]              r_p;
    logic signed [ldlt_pkg::ACC_W-1:0] r_acc;
    logic [ldlt_pkg::ADDR_W-1:0]     r_wa;
    logic                            r_s1_v, r_s2_v;
    logic [ldlt_pkg::OP_W-1:0]       r_s1_op, r_s2_op;
    logic [ldlt_pkg::IDX_W-1:0]      r_s1_vidx, r_s2_vidx;
    logic [2:0]                      r_s1_row, r_s1_col;
    logic                            r_s1_last;
    logic                            r_sing, r_sat;
    logic                            n_sing, n_sat;
    logic                            r_ov;
    ldlt_pkg::t_data                 r_oval;
    logic [2:0]                      r_orow, r_ocol;
    logic                            r_olast, r_osing, r_osat;

    logic                            pipe_op;
    logic signed [31:0]              mul_b;
    logic signed [63:0]              sh;
    logic signed [63:0]              acc64;
    ldlt_pkg::t_sat                  s2cl, fin, dq;
    ldlt_pkg::t_data                 zp_val;
    logic                            is_fdiag, is_foff, d_zero;
    logic                            div_start, div_run, div_done;
    logic signed [63:0]              div_quo;
    logic                            mem_we;
    logic [ldlt_pkg::ADDR_W-1:0]     mem_wa;
    ldlt_pkg::t_data                 mem_wd;

    always_comb begin
        pipe_op  = (i_cmd.op == ldlt_pkg::OP_LDT)   || (i_cmd.op == ldlt_pkg::OP_VMUL) ||
                   (i_cmd.op == ldlt_pkg::OP_LDACC) || (i_cmd.op == ldlt_pkg::OP_MAC)  ||
                   (i_cmd.op == ldlt_pkg::OP_OUT);
        is_fdiag = (i_cmd.op == ldlt_pkg::OP_FDIAG);
        is_foff  = (i_cmd.op == ldlt_pkg::OP_FOFF);
        d_zero   = (r_d == '0);
        mul_b    = (r_s1_op == ldlt_pkg::OP_VMUL) ? r_t : r_v[r_s1_vidx];
        sh       = r_p >>> ldlt_pkg::FRAC_W;
        s2cl     = ldlt_pkg::sat64(sh);
        acc64    = 64'(r_acc);
        fin      = ldlt_pkg::sat64(acc64);
        dq       = ldlt_pkg::sat64(div_quo);
        // zero pivot: quotient goes to the rail matching the numerator's sign, or zero for a zero numerator
        if (fin.val == '0) begin
            zp_val = '0;
        end else if (fin.val[31]) begin
            zp_val = ldlt_pkg::SAT_LO[31:0];
        end else begin
            zp_val = ldlt_pkg::SAT_HI[31:0];
        end
        div_start = is_foff && !d_zero;

        mem_we = 1'b1;
        mem_wa = i_cmd.addr;
        mem_wd = fin.val;
        priority if (i_cmd.ld_we) begin
            mem_wa = i_cmd.ld_addr;
            mem_wd = i_entry;
        end else if (is_fdiag) begin
            mem_wd = fin.val;
        end else if (is_foff && d_zero) begin
            mem_wd = zp_val;
        end else if (div_done) begin
            mem_wa = r_wa;
            mem_wd = dq.val;
        end else begin
            mem_we = 1'b0;
        end

        n_sing = r_sing | (is_foff && d_zero);
        n_sat  = r_sat
               | (r_s2_v && (r_s2_op == ldlt_pkg::OP_VMUL) && s2cl.sat)
               | (is_fdiag && fin.sat)
               | (is_foff && (fin.sat || (d_zero && fin.val != '0)))
               | (div_done && dq.sat);
        if (i_cmd.clr) begin
            n_sing = 1'b0;
            n_sat  = 1'b0;
        end
    end

    ldlt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (fin.val),
        .i_den   (r_d),
        .o_run   (div_run),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
            r_sing <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_s1_v <= pipe_op;
            r_s2_v <= r_s1_v && (r_s1_op != ldlt_pkg::OP_LDT) && (r_s1_op != ldlt_pkg::OP_OUT);
            r_sing <= n_sing;
            r_sat  <= n_sat;
            if (r_s1_v && r_s1_op == ldlt_pkg::OP_OUT) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end

        r_s1_op   <= i_cmd.op;
        r_s1_vidx <= i_cmd.vidx;
        r_s1_row  <= i_cmd.row;
        r_s1_col  <= i_cmd.col;
        r_s1_last <= i_cmd.last;
        r_s2_op   <= r_s1_op;
        r_s2_vidx <= r_s1_vidx;

        // stage 1: operand arrives from the store
        if (r_s1_op == ldlt_pkg::OP_LDT) begin
            r_t <= r_rdata;
        end
        if (r_s1_op == ldlt_pkg::OP_LDACC) begin
            r_p <= 64'($signed(r_rdata));
        end else begin
            r_p <= $signed(r_rdata) * mul_b;
        end
        if (r_s1_v && r_s1_op == ldlt_pkg::OP_OUT) begin
            r_oval  <= r_rdata;
            r_orow  <= r_s1_row;
            r_ocol  <= r_s1_col;
            r_olast <= r_s1_last;
            r_osing <= r_sing;
            r_osat  <= r_sat;
        end

        // stage 2: scale the product into v, or load or update the accumulator
        if (r_s2_v) begin
            unique case (r_s2_op)
                ldlt_pkg::OP_VMUL:  r_v[r_s2_vidx] <= s2cl.val;
                ldlt_pkg::OP_LDACC: r_acc <= r_p[ldlt_pkg::ACC_W-1:0];
                ldlt_pkg::OP_MAC:   r_acc <= r_acc - sh[ldlt_pkg::ACC_W-1:0];
                default: ;
            endcase
        end

        if (is_fdiag) begin
            r_d           <= fin.val;
            r_v[i_cmd.vidx] <= fin.val;
        end
        if (div_start) begin
            r_wa <= i_cmd.addr;
        end
    end

    assign o_stat.busy     = r_s1_v | r_s2_v | div_run | div_done;
    assign o_stat.out_full = r_ov;
    assign o_out_valid     = r_ov;
    assign o_result_value  = r_oval;
    assign o_row_index     = r_orow;
    assign o_col_index     = r_ocol;
    assign o_singular      = r_osing;
    assign o_saturated     = r_osat;
    assign o_last_result   = r_olast;

endmodule

@@ src/ldlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ldlt_ctrl
// Sequencer: loads entries, walks the factorization columns, emits results.
// ----------------------------------------------------------------------------
module ldlt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_last_entry,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_size,
    output ldlt_pkg::t_cmd       o_cmd,
    input  ldlt_pkg::t_stat      i_stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_COL  = 4'd1;
    localparam logic [3:0] S_VT   = 4'd2;
    localparam logic [3:0] S_VM   = 4'd3;
    localparam logic [3:0] S_VDRN = 4'd4;
    localparam logic [3:0] S_DACC = 4'd5;
    localparam logic [3:0] S_DMAC = 4'd6;
    localparam logic [3:0] S_DDRN = 4'd7;
    localparam logic [3:0] S_DFIN = 4'd8;
    localparam logic [3:0] S_RACC = 4'd9;
    localparam logic [3:0] S_RMAC = 4'd10;
    localparam logic [3:0] S_RDRN = 4'd11;
    localparam logic [3:0] S_RFIN = 4'd12;
    localparam logic [3:0] S_RWT  = 4'd13;
    localparam logic [3:0] S_ORD  = 4'd14;
    localparam logic [3:0] S_OWT  = 4'd15;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_k, n_k, r_i, n_i, r_r, n_r, r_c, n_c;
    logic [6:0]  r_count, n_count;
    logic [3:0]  r_size, n_size;
    logic [3:0]  n_eff;
    logic [2:0]  nm1, km1;
    logic [6:0]  total;
    logic [17:0] col_prod;
    logic [2:0]  ld_col, ld_row;
    logic [6:0]  row_full;
    logic        accept, out_last;

    always_comb begin
        n_eff = r_size;
        if (r_size == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_size > 4'(ldlt_pkg::MAX_ORDER)) begin
            n_eff = 4'(ldlt_pkg::MAX_ORDER);
        end
        nm1      = 3'(n_eff - 4'd1);
        km1      = r_k - 3'd1;
        total    = 7'({3'd0, n_eff} * {3'd0, n_eff});
        // column = count / n by reciprocal multiply, row is the remainder
        col_prod = 18'(r_count) * 18'(ldlt_pkg::recip(n_eff));
        ld_col   = col_prod[12:10];
        row_full = r_count - 7'({4'd0, ld_col} * {3'd0, n_eff});
        ld_row   = row_full[2:0];
        accept   = i_in_valid && (r_state == S_IDLE);
        out_last = (r_r == nm1) && (r_c == nm1);
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_r     = r_r;
        n_c     = r_c;
        n_count = r_count;
        n_size  = i_cfg_valid ? i_cfg_size : r_size;
        o_cmd   = '0;
        o_cmd.vidx = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < total) begin
                        o_cmd.ld_we   = 1'b1;
                        o_cmd.ld_addr = ldlt_pkg::addr_of(ld_row, ld_col);
                        n_count       = r_count + 7'd1;
                    end
                    if (i_last_entry) begin
                        o_cmd.clr = 1'b1;
                        n_count   = '0;
                        n_k       = '0;
                        n_state   = S_COL;
                    end
                end
            end
            S_COL: begin
                n_i     = '0;
                n_state = (r_k == 3'd0) ? S_DACC : S_VT;
            end
            S_VT: begin
                o_cmd.op   = ldlt_pkg::OP_LDT;
                o_cmd.addr = ldlt_pkg::addr_of(r_i, r_i);
                n_state    = S_VM;
            end
            S_VM: begin
                o_cmd.op   = ldlt_pkg::OP_VMUL;
                o_cmd.addr = ldlt_pkg::addr_of(r_k, r_i);
                n_i        = r_i + 3'd1;
                n_state    = (r_i == km1) ? S_VDRN : S_VT;
            end
            S_VDRN: begin
                if (!i_stat.busy) begin
                    n_state = S_DACC;
                end
            end
            S_DACC: begin
                o_cmd.op   = ldlt_pkg::OP_LDACC;
                o_cmd.addr = ldlt_pkg::addr_of(r_k, r_k);
                n_i        = '0;
                n_state    = (r_k == 3'd0) ? S_DDRN : S_DMAC;
            end
            S_DMAC: begin
                o_cmd.op   = ldlt_pkg::OP_MAC;
                o_cmd.addr = ldlt_pkg::addr_of(r_k, r_i);
                n_i        = r_i + 3'd1;
                if (r_i == km1) begin
                    n_state = S_DDRN;
                end
            end
            S_DDRN: begin
                if (!i_stat.busy) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.op   = ldlt_pkg::OP_FDIAG;
                o_cmd.addr = ldlt_pkg::addr_of(r_k, r_k);
                o_cmd.vidx = r_k;
                n_r        = r_k + 3'd1;
                if (r_k == nm1) begin
                    n_r     = '0;
                    n_c     = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_RACC;
                end
            end
            S_RACC: begin
                o_cmd.op   = ldlt_pkg::OP_LDACC;
                o_cmd.addr = ldlt_pkg::addr_of(r_r, r_k);
                n_i        = '0;
                n_state    = (r_k == 3'd0) ? S_RDRN : S_RMAC;
            end
            S_RMAC: begin
                o_cmd.op   = ldlt_pkg::OP_MAC;
                o_cmd.addr = ldlt_pkg::addr_of(r_r, r_i);
                n_i        = r_i + 3'd1;
                if (r_i == km1) begin
                    n_state = S_RDRN;
                end
            end
            S_RDRN: begin
                if (!i_stat.busy) begin
                    n_state = S_RFIN;
                end
            end
            S_RFIN: begin
                o_cmd.op   = ldlt_pkg::OP_FOFF;
                o_cmd.addr = ldlt_pkg::addr_of(r_r, r_k);
                n_state    = S_RWT;
            end
            S_RWT: begin
                // hold until the quotient is written back
                if (!i_stat.busy) begin
                    if (r_r == nm1) begin
                        n_k     = r_k + 3'd1;
                        n_state = S_COL;
                    end else begin
                        n_r     = r_r + 3'd1;
                        n_state = S_RACC;
                    end
                end
            end
            S_ORD: begin
                o_cmd.op   = ldlt_pkg::OP_OUT;
                o_cmd.addr = ldlt_pkg::addr_of(r_r, r_c);
                o_cmd.row  = r_r;
                o_cmd.col  = r_c;
                o_cmd.last = out_last;
                n_state    = S_OWT;
            end
            S_OWT: begin
                if (!i_stat.busy && !i_stat.out_full) begin
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else if (r_r == nm1) begin
                        n_r     = '0;
                        n_c     = r_c + 3'd1;
                        n_state = S_ORD;
                    end else begin
                        n_r     = r_r + 3'd1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_size  <= 4'(ldlt_pkg::MAX_ORDER);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_size  <= n_size;
        end
        r_k <= n_k;
        r_i <= n_i;
        r_r <= n_r;
        r_c <= n_c;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 7'd64)
        else $error("load count beyond store depth");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ORD) |-> !i_stat.out_full)
        else $error("output read issued while result still pending");
    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_we |-> ({1'b0, ld_row} < n_eff) && ({1'b0, ld_col} < n_eff))
        else $error("load position outside matrix");
    a_drained_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DFIN || r_state == S_RFIN) |-> !i_stat.busy)
        else $error("finish step with work in flight");
`endif

endmodule

@@ tb/tb_ldlt_factor_unpivoted_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ldlt_factor_unpivoted_unit
// Self-checking bench of the unpivoted LDL^T factor unit: loads symmetric
// Q16.16 matrices of every order, predicts the factored entries and flags,
// and compares each emitted entry in order, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_ldlt_factor_unpivoted_unit;

    localparam longint Q_ONE   = 64'sd65536;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam int     SETTLE  = 200;

    typedef enum int {MK_WELL, MK_NOISE, MK_ZERO_PIVOT, MK_EARLY, MK_OVERLONG} t_kind;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } t_entry;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               singular;
        logic               saturated;
        logic               last;
    } t_factored;

    logic i_clk;
    logic i_rst_n;

    ldlt_in_if  in_ch();
    ldlt_out_if out_ch();
    ldlt_cfg_if cfg_ch();

    ldlt_factor_unpivoted_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    t_entry    entry_queue[$];
    t_factored factored_queue[$];

    // predictor state
    longint      mstore[64];
    longint      vrow[8];
    int unsigned load_cnt;
    logic [3:0]  size_reg;
    bit          sing_flag;
    bit          sat_flag;

    int    errors;
    int    checked;
    int    items_sent;
    int    rounds;
    int    singular_rounds;
    int    saturated_rounds;
    bit    fast_in;
    bit    fast_out;
    int    in_gap;
    int    out_stall;
    logic signed [31:0] mtx[8][8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------ predictor
    function automatic int order_of(input logic [3:0] s);
        if (s == 4'd0) return 1;
        if (s > ldlt_pkg::MAX_ORDER) return ldlt_pkg::MAX_ORDER;
        return int'(s);
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > VAL_MAX) begin
            sat_flag = 1'b1;
            return VAL_MAX;
        end
        if (x < VAL_MIN) begin
            sat_flag = 1'b1;
            return VAL_MIN;
        end
        return x;
    endfunction

    // floor of the Q16.16 product
    function automatic longint qprod(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic void factor_matrix(input int n);
        longint acc, d, x;
        sing_flag = 1'b0;
        sat_flag  = 1'b0;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < k; i++)
                vrow[i] = clamp32(qprod(mstore[k + i*8], mstore[i + i*8]));
            acc = mstore[k + k*8];
            for (int i = 0; i < k; i++)
                acc -= qprod(mstore[k + i*8], vrow[i]);
            d = clamp32(acc);
            mstore[k + k*8] = d;
            vrow[k] = d;
            for (int r = k + 1; r < n; r++) begin
                acc = mstore[r + k*8];
                for (int i = 0; i < k; i++)
                    acc -= qprod(mstore[r + i*8], vrow[i]);
                x = clamp32(acc);
                if (d == 0) begin
                    sing_flag = 1'b1;
                    if (x > 0) begin
                        sat_flag = 1'b1;
                        x = VAL_MAX;
                    end else if (x < 0) begin
                        sat_flag = 1'b1;
                        x = VAL_MIN;
                    end
                    mstore[r + k*8] = x;
                end else begin
                    mstore[r + k*8] = clamp32((x * Q_ONE) / d);
                end
            end
        end
    endfunction

    function automatic void accept_entry(input t_entry e);
        int n;
        t_factored f;
        n = order_of(size_reg);
        if (load_cnt < n*n) begin
            mstore[(load_cnt % n) + (load_cnt / n)*8] = longint'(e.value);
            load_cnt++;
        end
        if (!e.last) return;
        factor_matrix(n);
        rounds++;
        if (sing_flag) singular_rounds++;
        if (sat_flag) saturated_rounds++;
        for (int c = 0; c < n; c++) begin
            for (int r = 0; r < n; r++) begin
                f.value     = mstore[r + c*8][31:0];
                f.row       = r[2:0];
                f.col       = c[2:0];
                f.singular  = sing_flag;
                f.saturated = sat_flag;
                f.last      = (r == n-1) && (c == n-1);
                factored_queue.push_back(f);
            end
        end
        load_cnt = 0;
    endfunction

    // ------------------------------------------------------------ driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end else if (entry_queue.size() != 0) begin
                t_entry e;
                e = entry_queue.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.entry_value <= e.value;
                in_ch.last_entry  <= e.last;
                in_gap            <= fast_in ? 0 : $urandom_range(0, 8);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            int s;
            s = fast_out ? 0 : $urandom_range(0, 8);
            out_stall    <= s;
            out_ch.ready <= (s == 0);
        end else if (out_stall > 0) begin
            out_stall    <= out_stall - 1;
            out_ch.ready <= (out_stall == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------ monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                size_reg = cfg_ch.matrix_size;
            if (in_ch.valid && in_ch.ready)
                accept_entry('{in_ch.entry_value, in_ch.last_entry});
            if (out_ch.valid && out_ch.ready) begin
                if (factored_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result r%0d c%0d value %h",
                                 out_ch.row_index, out_ch.col_index,
                                 out_ch.result_value);
                end else begin
                    t_factored f;
                    f = factored_queue.pop_front();
                    checked++;
                    if (out_ch.result_value !== f.value || out_ch.row_index !== f.row ||
                        out_ch.col_index !== f.col || out_ch.singular !== f.singular ||
                        out_ch.saturated !== f.saturated ||
                        out_ch.last_result !== f.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp v=%h r%0d c%0d sing=%b sat=%b last=%b",
                                      " got v=%h r%0d c%0d sing=%b sat=%b last=%b"},
                                     f.value, f.row, f.col, f.singular, f.saturated,
                                     f.last,
                                     out_ch.result_value, out_ch.row_index,
                                     out_ch.col_index, out_ch.singular,
                                     out_ch.saturated, out_ch.last_result);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------ stimulus
    task automatic push_entry(input logic signed [31:0] v, input logic last);
        entry_queue.push_back('{v, last});
        items_sent++;
    endtask

    task automatic drain();
        while (entry_queue.size() != 0 || in_ch.valid || factored_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] s);
        drain();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.matrix_size <= s;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_q(input int span);
        return $signed($urandom_range(0, 2*span)) - span;
    endfunction

    // fill mtx with a symmetric matrix of the given kind
    task automatic make_matrix(input int n, input t_kind kind);
        for (int c = 0; c < n; c++) begin
            for (int r = c; r < n; r++) begin
                if (kind == MK_NOISE)
                    mtx[r][c] = $urandom();
                else if (r == c)
                    mtx[r][c] = n*65536 + $urandom_range(0, 4*65536);
                else
                    mtx[r][c] = rand_q(65536);
                mtx[c][r] = mtx[r][c];
            end
        end
        if (kind == MK_ZERO_PIVOT) mtx[0][0] = 0;
    endtask

    task automatic send_matrix(input int n, input t_kind kind);
        int cnt;
        make_matrix(n, kind);
        fast_in  = ($urandom_range(0, 3) == 0);
        fast_out = ($urandom_range(0, 3) == 0);
        cnt = n*n;
        if (kind == MK_EARLY) cnt = $urandom_range(1, n*n);
        for (int k = 0; k < cnt; k++)
            push_entry(mtx[k % n][k / n],
                       (kind != MK_OVERLONG) && (k == cnt-1));
        if (kind == MK_OVERLONG) begin
            repeat ($urandom_range(1, 4)) push_entry($urandom(), 1'b0);
            push_entry($urandom(), 1'b1);
        end
    endtask

    initial begin
        int sz;
        int pick;
        t_kind kind;
        in_ch.valid        = 1'b0;
        in_ch.entry_value  = '0;
        in_ch.last_entry   = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.matrix_size = 4'd8;
        size_reg  = 4'd8;
        load_cnt  = 0;
        sing_flag = 1'b0;
        sat_flag  = 1'b0;
        errors = 0; checked = 0; items_sent = 0;
        rounds = 0; singular_rounds = 0; saturated_rounds = 0;
        fast_in = 1'b0; fast_out = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full order-8 matrix first so every store entry holds a value
        send_matrix(8, MK_WELL);

        // order 1: extremes and zero
        write_size(4'd1);
        push_entry(32'sh7fff_ffff, 1'b1);
        push_entry(32'sh8000_0000, 1'b1);
        push_entry(32'sh0000_0000, 1'b1);

        // order 2: a nonzero pivot, zero pivot with negative and zero numerators, then an overlong stream
        write_size(4'd2);
        push_entry(32'sh0001_0000, 1'b0); push_entry(32'sh0001_0000, 1'b0);
        push_entry(32'sh0001_0000, 1'b0); push_entry(32'sh0001_0000, 1'b1);
        push_entry(32'sh0000_0000, 1'b0); push_entry(-32'sh0001_0000, 1'b0);
        push_entry(-32'sh0001_0000, 1'b0); push_entry(32'sh0005_0000, 1'b1);
        push_entry(32'sh0000_0000, 1'b0); push_entry(32'sh0000_0000, 1'b0);
        push_entry(32'sh0000_0000, 1'b0); push_entry(32'sh0003_0000, 1'b1);
        send_matrix(2, MK_OVERLONG);

        // order 3 with an early last entry
        write_size(4'd3);
        send_matrix(3, MK_EARLY);

        // out-of-range sizes: zero acts as one, fifteen as eight
        write_size(4'd0);
        push_entry(32'sh1234_5678, 1'b1);
        write_size(4'd15);
        send_matrix(8, MK_NOISE);

        while (items_sent < 430) begin
            if ($urandom_range(0, 9) < 4) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)      sz = 0;
                else if (pick == 1) sz = 15;
                else if (pick < 4)  sz = $urandom_range(5, 8);
                else                sz = $urandom_range(1, 4);
                write_size(sz[3:0]);
            end
            pick = $urandom_range(0, 19);
            if (pick < 13)      kind = MK_WELL;
            else if (pick < 15) kind = MK_NOISE;
            else if (pick < 17) kind = MK_ZERO_PIVOT;
            else if (pick < 18) kind = MK_EARLY;
            else                kind = MK_OVERLONG;
            if (kind == MK_ZERO_PIVOT && order_of(size_reg) == 1) kind = MK_WELL;
            send_matrix(order_of(size_reg), kind);
        end

        drain();
        $display("covered %0d entries in %0d factorizations, %0d results checked",
                 items_sent, rounds, checked);
        $display("%0d rounds hit a zero pivot, %0d rounds saturated",
                 singular_rounds, saturated_rounds);
        if (errors == 0 && factored_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ ldlt_factor_unpivoted_unit.f @@
src/ldlt_pkg.sv
src/ldlt_if.sv
src/ldlt_div.sv
src/ldlt_dp.sv
src/ldlt_ctrl.sv
src/ldlt_factor_unpivoted_unit.sv
tb/tb_ldlt_factor_unpivoted_unit.sv
